// File: hdl/vwsa_pkg.sv
// ----------------------------------------------------------------------------
// vwsa_pkg - shared types and constants for the waveform scope accumulator
// Scope geometry, register codes, BT.709 Q0.16 coefficients, sequencer and
// arithmetic unit control types.
// ----------------------------------------------------------------------------
package vwsa_pkg;

  // scope geometry
  localparam int SCOPE_WIDTH  = 256;
  localparam int SCOPE_HEIGHT = 256;
  localparam int COL_W  = (SCOPE_WIDTH  > 1) ? $clog2(SCOPE_WIDTH)  : 1;
  localparam int ROW_W  = (SCOPE_HEIGHT > 1) ? $clog2(SCOPE_HEIGHT) : 1;
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH  = SCOPE_WIDTH * SCOPE_HEIGHT;

  // arithmetic unit widths
  localparam int COEF_W = 18;
  localparam int OPND_W = 8;
  localparam int ACC_W  = 27;

  // input op codes
  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_STEP = 2'd1;
  localparam logic [1:0] CFG_ROWS = 2'd2;

  // scope modes
  localparam logic [1:0] MODE_LUMA = 2'd0;
  localparam logic [1:0] MODE_RGB  = 2'd1;
  localparam logic [1:0] MODE_YCC  = 2'd2;

  // coefficient sets
  localparam logic [1:0] SET_Y  = 2'd0;
  localparam logic [1:0] SET_CB = 2'd1;
  localparam logic [1:0] SET_CR = 2'd2;

  localparam logic signed [ACC_W-1:0] CHROMA_BIAS = 27'sd8388608;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_MAP,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RD_RD,
    ST_RD_CLR
  } state_t;

  typedef enum logic [1:0] {
    ALU_HOLD,
    ALU_MAC,
    ALU_MAP
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    first;   // MAC starts from the bias instead of the accumulator
  } alu_ctl_t;

  // Q0.16 coefficient for component idx (0 red, 1 green, 2 blue) of a set
  function automatic logic signed [COEF_W-1:0] coef_f(input logic [1:0] set,
                                                      input logic [1:0] idx);
    logic signed [COEF_W-1:0] c;
    case ({set, idx})
      {SET_Y,  2'd0}: c = 18'sd13933;
      {SET_Y,  2'd1}: c = 18'sd46871;
      {SET_Y,  2'd2}: c = 18'sd4732;
      {SET_CB, 2'd0}: c = -18'sd7510;
      {SET_CB, 2'd1}: c = -18'sd25258;
      {SET_CB, 2'd2}: c = 18'sd32768;
      {SET_CR, 2'd0}: c = 18'sd32768;
      {SET_CR, 2'd1}: c = -18'sd29767;
      {SET_CR, 2'd2}: c = -18'sd3001;
      default:        c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [ACC_W-1:0] bias_f(input logic [1:0] set);
    logic signed [ACC_W-1:0] b;
    case (set)
      SET_CB, SET_CR: b = CHROMA_BIAS;
      default:        b = '0;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/vwsa_alu.sv
// ----------------------------------------------------------------------------
// vwsa_alu - shared multiply-accumulate unit
// One signed 18x9 multiplier feeding a single accumulator register. Used for
// the luma/chroma dot products and for the value-to-row scaling product.
// ----------------------------------------------------------------------------
module vwsa_alu (
  input  logic                                   clk,
  input  vwsa_pkg::alu_ctl_t                     ctl,
  input  logic signed [vwsa_pkg::COEF_W-1:0]     coef,
  input  logic        [vwsa_pkg::OPND_W-1:0]     opnd,
  input  logic signed [vwsa_pkg::ACC_W-1:0]      bias,
  output logic signed [vwsa_pkg::ACC_W-1:0]      acc
);
  import vwsa_pkg::*;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] coef_x;
  logic signed [ACC_W-1:0] opnd_x;

  // operands widened first so the product keeps all of its bits
  assign coef_x = ACC_W'(coef);
  assign opnd_x = ACC_W'($signed({1'b0, opnd}));
  assign prod   = coef_x * opnd_x;

  always_comb begin
    case (ctl.op)
      ALU_MAC: acc_nxt = (ctl.first ? bias : acc_r) + prod;
      ALU_MAP: acc_nxt = prod;
      default: acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// File: hdl/video_waveform_scope_accumulator.sv
// ----------------------------------------------------------------------------
// video_waveform_scope_accumulator - BT.709 waveform scope cell accumulator
// Sequence: a read op reads the cell, then clears it and loads the output
//   register; an accumulate runs the shared MAC unit and a read-modify-write
//   of the scope memory per hit: one hit for luma, three for RGB and YCbCr.
// Flow: one item is taken at a time; a read is held longer while a result
//   waits in the output register, and a dropped pixel does not stall the
//   input. in_stall is high while busy.
// Reset: synchronous, active low; then a sweep clears the
//   scope memory to black, in_stall high throughout. Config writes allowed.
// ----------------------------------------------------------------------------
module video_waveform_scope_accumulator (
  input  logic       clk,
  input  logic       rst_n,
  // config write port
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_column,
  input  logic [7:0] in_row,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_cell_red,
  output logic [7:0] out_cell_green,
  output logic [7:0] out_cell_blue
);
  import vwsa_pkg::*;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [1:0] mode_r;
  logic [3:0] step_r;
  logic [8:0] rows_r;

  // --------------------------------------------------------------------------
  // Sequencer state and latched item
  // --------------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [1:0]        pass_r;      // hit number within one pixel
  logic [1:0]        mac_cnt_r;   // component number within a dot product
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  rd_row_r;
  logic [7:0]        red_r, green_r, blue_r;
  logic              rd_hit_r;    // read op addresses a real cell
  logic [ADDR_W-1:0] addr_r;      // cell under read-modify-write
  logic [23:0]       rdata_r;

  logic              out_valid_r;
  logic [7:0]        out_red_r, out_green_r, out_blue_r;

  // scope memory, {column, row} addressing
  logic [23:0] mem [0:DEPTH-1];

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic              in_xfer;
  logic              col_ok, row_ok, acc_ok;
  logic              out_free;
  logic              last_pass;
  logic [8:0]        rows_eff;
  logic [ROW_W-1:0]  rows_m1;
  logic [3:0]        step_eff;
  logic [1:0]        coef_set;
  logic [2:0]        chan_mask;   // red, green, blue
  logic [7:0]        pass_comp;
  logic [7:0]        mac_comp;
  logic [7:0]        clamp_val;
  logic [16:0]       div_sum;
  logic [ROW_W-1:0]  hit_row;
  logic [23:0]       bumped;

  alu_ctl_t                 alu_ctl;
  logic signed [COEF_W-1:0] alu_coef;
  logic [OPND_W-1:0]        alu_opnd;
  logic signed [ACC_W-1:0]  alu_acc;

  logic              mem_rd, mem_we, out_load;
  logic [ADDR_W-1:0] mem_rd_addr, mem_wr_addr;
  logic [23:0]       mem_wr_data;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign col_ok = (32'(in_column) < SCOPE_WIDTH);
  assign row_ok = (32'(in_row) < SCOPE_HEIGHT);
  assign acc_ok = col_ok && (rows_r != 9'd0) &&
                  (mode_r inside {MODE_LUMA, MODE_RGB, MODE_YCC});

  assign rows_eff = (32'(rows_r) > SCOPE_HEIGHT) ? 9'(SCOPE_HEIGHT) : rows_r;
  assign rows_m1  = ROW_W'(rows_eff - 9'd1);
  assign step_eff = (step_r == 4'd0) ? 4'd1 : step_r;

  assign last_pass = (mode_r == MODE_LUMA) || (pass_r == 2'd2);
  assign coef_set  = (mode_r == MODE_YCC) ? pass_r : SET_Y;

  // channels hit on each pass
  always_comb begin
    case ({mode_r, pass_r})
      {MODE_RGB, 2'd0}: chan_mask = 3'b100;
      {MODE_RGB, 2'd1}: chan_mask = 3'b010;
      {MODE_RGB, 2'd2}: chan_mask = 3'b001;
      {MODE_YCC, 2'd1}: chan_mask = 3'b001;   // Cb row bumps blue
      {MODE_YCC, 2'd2}: chan_mask = 3'b100;   // Cr row bumps red
      default:          chan_mask = 3'b111;   // luma row bumps all
    endcase
  end

  always_comb begin
    case (pass_r)
      2'd0:    pass_comp = red_r;
      2'd1:    pass_comp = green_r;
      default: pass_comp = blue_r;
    endcase
  end

  always_comb begin
    case (mac_cnt_r)
      2'd0:    mac_comp = red_r;
      2'd1:    mac_comp = green_r;
      default: mac_comp = blue_r;
    endcase
  end

  // Q.16 dot product -> 0..255, negative clamps to 0
  assign clamp_val = alu_acc[ACC_W-1] ? 8'd0 :
                     (|alu_acc[ACC_W-2:24]) ? 8'hFF : alu_acc[23:16];

  // v*(rows-1)/255 via (p + (p >> 8) + 1) >> 8, exact for p below 65280
  assign div_sum = {1'b0, alu_acc[15:0]} + 17'(alu_acc[15:8]) + 17'd1;
  assign hit_row = rows_m1 - ROW_W'(div_sum[15:8]);

  // saturating add of the step into the selected channels
  always_comb begin
    logic [8:0] s_r, s_g, s_b;
    s_r = {1'b0, rdata_r[23:16]} + 9'(step_eff);
    s_g = {1'b0, rdata_r[15:8]}  + 9'(step_eff);
    s_b = {1'b0, rdata_r[7:0]}   + 9'(step_eff);
    bumped = rdata_r;
    if (chan_mask[2]) bumped[23:16] = s_r[8] ? 8'hFF : s_r[7:0];
    if (chan_mask[1]) bumped[15:8]  = s_g[8] ? 8'hFF : s_g[7:0];
    if (chan_mask[0]) bumped[7:0]   = s_b[8] ? 8'hFF : s_b[7:0];
  end

  // --------------------------------------------------------------------------
  // Shared multiply-accumulate unit
  // --------------------------------------------------------------------------
  vwsa_alu u_alu (
    .clk  (clk),
    .ctl  (alu_ctl),
    .coef (alu_coef),
    .opnd (alu_opnd),
    .bias (bias_f(coef_set)),
    .acc  (alu_acc)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_op == OP_READ) begin
            state_nxt = (col_ok && row_ok) ? ST_RD_RD : ST_RD_CLR;
          end else if (acc_ok) begin
            state_nxt = (mode_r == MODE_RGB) ? ST_MAP : ST_MAC;
          end
        end
      end
      ST_MAC: begin
        if (mac_cnt_r == 2'd2) state_nxt = ST_MAP;
      end
      ST_MAP:    state_nxt = ST_RMW_RD;
      ST_RMW_RD: state_nxt = ST_RMW_WR;
      ST_RMW_WR: begin
        if (last_pass)               state_nxt = ST_IDLE;
        else if (mode_r == MODE_RGB) state_nxt = ST_MAP;
        else                         state_nxt = ST_MAC;
      end
      ST_RD_RD: state_nxt = ST_RD_CLR;
      ST_RD_CLR: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    alu_ctl     = '{op: ALU_HOLD, first: 1'b0};
    alu_coef    = coef_f(coef_set, mac_cnt_r);
    alu_opnd    = mac_comp;
    mem_rd      = 1'b0;
    mem_rd_addr = {col_r, hit_row};
    mem_we      = 1'b0;
    mem_wr_addr = addr_r;
    mem_wr_data = bumped;
    out_load    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wr_addr = clr_cnt_r;
        mem_wr_data = '0;
      end
      ST_MAC: begin
        alu_ctl = '{op: ALU_MAC, first: (mac_cnt_r == 2'd0)};
      end
      ST_MAP: begin
        // scale the value by rows-1; RGB mode uses the raw component
        alu_ctl  = '{op: ALU_MAP, first: 1'b0};
        alu_coef = $signed({{(COEF_W-ROW_W){1'b0}}, rows_m1});
        alu_opnd = (mode_r == MODE_RGB) ? pass_comp : clamp_val;
      end
      ST_RMW_RD: begin
        mem_rd = 1'b1;
      end
      ST_RMW_WR: begin
        mem_we = 1'b1;
      end
      ST_RD_RD: begin
        mem_rd      = 1'b1;
        mem_rd_addr = {col_r, rd_row_r};
      end
      ST_RD_CLR: begin
        // read-and-clear: wait for room in the output register
        if (out_free) begin
          out_load    = 1'b1;
          mem_we      = rd_hit_r;
          mem_wr_data = '0;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Scope memory: one write and one registered read per cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wr_addr] <= mem_wr_data;
    if (mem_rd) rdata_r <= mem[mem_rd_addr];
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pass_r      <= 2'd0;
      mac_cnt_r   <= 2'd0;
      mode_r      <= MODE_LUMA;
      step_r      <= 4'd7;
      rows_r      <= 9'd256;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;

      if (in_xfer)                   pass_r <= 2'd0;
      else if (state_r == ST_RMW_WR) pass_r <= pass_r + 2'd1;

      mac_cnt_r <= (state_r == ST_MAC && mac_cnt_r != 2'd2) ? mac_cnt_r + 2'd1 : 2'd0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE: mode_r <= cfg_wdata[1:0];
          CFG_STEP: step_r <= cfg_wdata[3:0];
          CFG_ROWS: rows_r <= cfg_wdata;
          default:  ;
        endcase
      end

      if (out_load)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      col_r    <= in_column[COL_W-1:0];
      rd_row_r <= in_row[ROW_W-1:0];
      red_r    <= in_red;
      green_r  <= in_green;
      blue_r   <= in_blue;
      rd_hit_r <= col_ok && row_ok;
    end
    if (mem_rd) addr_r <= mem_rd_addr;
    if (out_load) begin
      out_red_r   <= rd_hit_r ? rdata_r[23:16] : 8'd0;
      out_green_r <= rd_hit_r ? rdata_r[15:8]  : 8'd0;
      out_blue_r  <= rd_hit_r ? rdata_r[7:0]   : 8'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_red   = out_red_r;
  assign out_cell_green = out_green_r;
  assign out_cell_blue  = out_blue_r;

endmodule
